// ===== src/fifo_recent_id_list_macros.svh =====
// Assertion macros shared by the fifo_recent_id_list RTL.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef FIFO_RECENT_ID_LIST_MACROS_SVH
`define FIFO_RECENT_ID_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FRIL_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FRIL_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fril_pkg.sv =====
// Package for fifo_recent_id_list: field widths, command codes, payload and state types.
// No dependencies.
package fril_pkg;

   localparam int ID_W  = 32;
   localparam int OCC_W = 5;
   localparam int CSR_W = 5;

   localparam logic [CSR_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_DUMP  = 1'b1;

   typedef struct packed {
      logic            command;
      logic [ID_W-1:0] id_value;
   } req_payload_type;

   typedef struct packed {
      logic             hit;
      logic             evicted_valid;
      logic [ID_W-1:0]  evicted_id;
      logic [OCC_W-1:0] occupancy;
      logic             entry_valid;
      logic [ID_W-1:0]  entry_id;
      logic             last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DUMP_RD,
      ST_DUMP_LOAD,
      ST_RESP
   } state_type;

endpackage

// ===== src/fril_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on fril_pkg for the payload types.
interface fril_req_if;
   import fril_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface fril_rsp_if;
   import fril_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/fril_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fril_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fifo_recent_id_list.sv =====
// fifo_recent_id_list: FIFO-replacement store of distinct ids (ring buffer in fril_ram),
// built on fril_pkg, fril_if and fril_ram. One sequencer walks the RAM read port.
// Offer: ids are read oldest first; a hit ends the scan early, a miss appends the id.
// Dump: per id a read, a load and a held result; an empty store gives one blank result.
// Throughput: one transaction at a time, the next taken the cycle after its last result.
// Reset (synchronous): store empty, capacity 16; entries stay undefined until written.
module fifo_recent_id_list #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   fril_req_if.sink               req_chan,
   fril_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [fril_pkg::CSR_W-1:0] csr_wdata
);
   import fril_pkg::*;

   `include "fifo_recent_id_list_macros.svh"

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   // Control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [SLOT_W-1:0]   oldest_ff, oldest_in;
   logic [CSR_W-1:0]    capacity_ff, capacity_in;
   logic                cmp_valid_ff, cmp_valid_in;

   // Working registers of the current transaction
   logic                cmd_ff, cmd_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]   ptr_ff, ptr_in;
   logic                cmp_first_ff, cmp_first_in;
   logic [ID_W-1:0]     oldest_data_ff, oldest_data_in;
   rsp_payload_type     rsp_ff, rsp_in;

   // RAM port
   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_wr_addr;
   logic                ram_rd_en;
   logic [SLOT_W-1:0]   ram_rd_addr;
   logic [ID_W-1:0]     ram_rd_data;

   // Derived values
   logic [CAP_W-1:0]    cap_floor;
   logic [CAP_W-1:0]    eff_cap;
   logic                store_full;
   logic [SLOT_W-1:0]   newest_slot;
   logic [SLOT_W-1:0]   free_slot;
   logic                req_take;
   logic                rsp_take;

   // Ring arithmetic: base < DEPTH, offset <= DEPTH, so one subtract wraps the sum
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(DEPTH - 1) : s - 1'b1;
   endfunction

   fril_ram #(
      .WIDTH (ID_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (id_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Capacity of zero behaves as one; anything above DEPTH behaves as DEPTH
   assign cap_floor  = (capacity_ff == '0) ? CAP_W'(1) : CAP_W'(capacity_ff);
   assign eff_cap    = (cap_floor > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_floor;
   assign store_full = CAP_W'(held_ff) >= eff_cap;

   // Newest entry sits held-1 places after the oldest; a new id goes just after it
   assign newest_slot = slot_of(oldest_ff, held_ff - 1'b1);
   assign free_slot   = slot_of(oldest_ff, held_ff);

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = (state_ff == ST_RESP);
   assign rsp_chan.payload = rsp_ff;

   assign capacity_in = csr_we ? csr_wdata : capacity_ff;

   always_comb begin
      state_in       = state_ff;
      held_in        = held_ff;
      oldest_in      = oldest_ff;
      cmp_valid_in   = cmp_valid_ff;
      cmd_in         = cmd_ff;
      id_in          = id_ff;
      idx_in         = idx_ff;
      ptr_in         = ptr_ff;
      cmp_first_in   = cmp_first_ff;
      oldest_data_in = oldest_data_ff;
      rsp_in         = rsp_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = free_slot;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in       = req_chan.payload.command;
               id_in        = req_chan.payload.id_value;
               idx_in       = '0;
               cmp_valid_in = 1'b0;
               cmp_first_in = 1'b0;
               if (req_chan.payload.command == CMD_DUMP) begin
                  ptr_in = newest_slot;
                  if (held_ff == '0) begin
                     // Empty store: a single blank result closes the dump
                     rsp_in      = '0;
                     rsp_in.last = 1'b1;
                     state_in    = ST_RESP;
                  end else begin
                     state_in = ST_DUMP_RD;
                  end
               end else begin
                  ptr_in   = oldest_ff;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Read one entry a cycle, oldest first; compare the previous read
            cmp_valid_in = 1'b0;
            cmp_first_in = 1'b0;
            if (cmp_valid_ff && cmp_first_ff) begin
               oldest_data_in = ram_rd_data;
            end
            if (cmp_valid_ff && (ram_rd_data == id_ff)) begin
               rsp_in           = '0;
               rsp_in.hit       = 1'b1;
               rsp_in.occupancy = OCC_W'(held_ff);
               rsp_in.last      = 1'b1;
               state_in         = ST_RESP;
            end else if (idx_ff < held_ff) begin
               ram_rd_en    = 1'b1;
               ptr_in       = slot_inc(ptr_ff);
               idx_in       = idx_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_first_in = (idx_ff == '0);
            end else if (!cmp_valid_ff) begin
               // Miss: append the id, evicting the oldest when full
               ram_wr_en   = 1'b1;
               rsp_in      = '0;
               rsp_in.last = 1'b1;
               if (store_full) begin
                  oldest_in            = slot_inc(oldest_ff);
                  rsp_in.evicted_valid = 1'b1;
                  rsp_in.evicted_id    = oldest_data_ff;
                  rsp_in.occupancy     = OCC_W'(held_ff);
               end else begin
                  held_in          = held_ff + 1'b1;
                  rsp_in.occupancy = OCC_W'(held_ff + 1'b1);
               end
               state_in = ST_RESP;
            end
         end

         ST_DUMP_RD: begin
            // Walk newest to oldest
            ram_rd_en = 1'b1;
            ptr_in    = slot_dec(ptr_ff);
            idx_in    = idx_ff + 1'b1;
            state_in  = ST_DUMP_LOAD;
         end

         ST_DUMP_LOAD: begin
            rsp_in             = '0;
            rsp_in.occupancy   = OCC_W'(held_ff);
            rsp_in.entry_valid = 1'b1;
            rsp_in.entry_id    = ram_rd_data;
            rsp_in.last        = (idx_ff == held_ff);
            state_in           = ST_RESP;
         end

         ST_RESP: begin
            // Hold the result until taken
            if (rsp_take) begin
               if ((cmd_ff == CMD_DUMP) && !rsp_ff.last) begin
                  state_in = ST_DUMP_RD;
               end else begin
                  state_in = ST_IDLE;
                  if (cmd_ff == CMD_DUMP) begin
                     held_in   = '0;
                     oldest_in = '0;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         oldest_ff    <= '0;
         capacity_ff  <= CAPACITY_RESET;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         oldest_ff    <= oldest_in;
         capacity_ff  <= capacity_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      id_ff          <= id_in;
      idx_ff         <= idx_in;
      ptr_ff         <= ptr_in;
      cmp_first_ff   <= cmp_first_in;
      oldest_data_ff <= oldest_data_in;
      rsp_ff         <= rsp_in;
   end

   `FRIL_ASSERT_NXT(a_busy_after_req, req_take, state_ff != ST_IDLE,
                    "sequencer idle after accepting a transaction")
   `FRIL_ASSERT_NXT(a_dump_clears, rsp_take && (cmd_ff == CMD_DUMP) && rsp_ff.last,
                    (held_ff == '0) && (oldest_ff == '0), "store not cleared after dump")
   `FRIL_ASSERT_IMP(a_held_bound, 1'b1, held_ff <= CNT_W'(DEPTH),
                    "occupancy above store depth")
   `FRIL_ASSERT_IMP(a_write_after_scan, ram_wr_en, (state_ff == ST_SCAN) && !cmp_valid_ff,
                    "store written outside the end of a scan")
   `FRIL_ASSERT_NXT(a_offer_single, rsp_take && (cmd_ff == CMD_OFFER), state_ff == ST_IDLE,
                    "offer produced more than one result")

endmodule

// ===== tb/fifo_recent_id_list_tb.sv =====
// Self-checking testbench for fifo_recent_id_list: a directed table, then random phases.
// Depends on fril_pkg and fril_if. Each result is compared with a predictor of the id list.
module fifo_recent_id_list_tb;
   import fril_pkg::*;

   localparam int DEPTH           = 16;
   localparam int SLOT_W          = $clog2(DEPTH);
   localparam int POOL_SIZE       = 16;
   localparam int POOL_IDX_W      = $clog2(POOL_SIZE);
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 4000;
   localparam int TAIL_CYCLES     = 64;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 16;
   localparam int REPORT_LINES    = 40;
   localparam int NORMAL_IDLE_PCT = 17;

   // A row of stimulus is either a request transaction or a capacity write.
   typedef enum logic {
      ROW_ITEM,
      ROW_CAPACITY
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [CSR_W-1:0]  capacity;
      req_payload_type   item;
      logic              has_typed;
      rsp_payload_type   typed_rsp;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   fril_req_if req_chan ();
   fril_rsp_if rsp_chan ();

   fifo_recent_id_list #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: a ring of held ids, its fill level and its oldest slot.
   logic [ID_W-1:0]  held_ids [DEPTH];
   int unsigned      held_total;
   int unsigned      oldest_pos;
   logic [CSR_W-1:0] capacity_setting;

   rsp_payload_type  pending_results [$];
   rsp_payload_type  wanted;
   row_type          directed_rows [$];
   row_type          cur_row;
   logic [ID_W-1:0]  id_pool [POOL_SIZE];

   int               fail_count      = 0;
   int               results_checked = 0;
   int               idle_percent    = NORMAL_IDLE_PCT;
   bit               hold_off_request = 1'b0;

   // Free-running clock, period of two units.
   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Queue helpers: append at the tail
   // ------------------------------------------------------------------
   task automatic queue_result(input rsp_payload_type r);
      pending_results.insert(pending_results.size(), r);
   endtask

   task automatic add_row(input row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // ------------------------------------------------------------------
   // Row builders for the stimulus table
   // ------------------------------------------------------------------
   function automatic row_type offer_row(input logic [ID_W-1:0] id);
      row_type r;
      r               = '0;
      r.kind          = ROW_ITEM;
      r.item.command  = CMD_OFFER;
      r.item.id_value = id;
      return r;
   endfunction

   function automatic row_type dump_row();
      row_type r;
      r              = '0;
      r.kind         = ROW_ITEM;
      r.item.command = CMD_DUMP;
      // Dumps ignore the id; fill it anyway so stray decoding would show up.
      r.item.id_value = $urandom();
      return r;
   endfunction

   function automatic row_type capacity_row(input logic [CSR_W-1:0] value);
      row_type r;
      r          = '0;
      r.kind     = ROW_CAPACITY;
      r.capacity = value;
      return r;
   endfunction

   // Attach a hand-written single result to a row; last is always set.
   function automatic row_type typed_row(input row_type r, input logic hit,
                                         input logic ev_valid, input logic [ID_W-1:0] ev_id,
                                         input logic [OCC_W-1:0] occ, input logic en_valid,
                                         input logic [ID_W-1:0] en_id);
      row_type t;
      t                         = r;
      t.has_typed               = 1'b1;
      t.typed_rsp.hit           = hit;
      t.typed_rsp.evicted_valid = ev_valid;
      t.typed_rsp.evicted_id    = ev_id;
      t.typed_rsp.occupancy     = occ;
      t.typed_rsp.entry_valid   = en_valid;
      t.typed_rsp.entry_id      = en_id;
      t.typed_rsp.last          = 1'b1;
      return t;
   endfunction

   // ------------------------------------------------------------------
   // Predictor: work out the results of one accepted request transaction
   // ------------------------------------------------------------------
   task automatic predict_results(input req_payload_type item);
      rsp_payload_type r;
      int unsigned     eff_cap;
      int unsigned     i;
      bit              found;
      r = '0;
      if (item.command == CMD_DUMP) begin
         if (held_total == 0) begin
            // Empty store: a single blank result marked last.
            r.last = 1'b1;
            queue_result(r);
         end else begin
            // Newest first, occupancy as it stood before the dump.
            for (i = 0; i < held_total; i++) begin
               r             = '0;
               r.occupancy   = OCC_W'(held_total);
               r.entry_valid = 1'b1;
               r.entry_id    = held_ids[SLOT_W'((oldest_pos + held_total - 1 - i) % DEPTH)];
               r.last        = (i + 1 == held_total);
               queue_result(r);
            end
         end
         held_total = 0;
         oldest_pos = 0;
      end else begin
         found = 1'b0;
         for (i = 0; i < held_total; i++) begin
            if (held_ids[SLOT_W'((oldest_pos + i) % DEPTH)] == item.id_value) found = 1'b1;
         end
         // Out-of-range capacity is clamped into 1..DEPTH.
         eff_cap = 32'(capacity_setting);
         if (eff_cap < 1) eff_cap = 1;
         if (eff_cap > DEPTH) eff_cap = DEPTH;
         r.last = 1'b1;
         if (found) begin
            r.hit       = 1'b1;
            r.occupancy = OCC_W'(held_total);
         end else if (held_total >= eff_cap) begin
            // Evict only the single oldest entry, even when over capacity.
            r.evicted_valid = 1'b1;
            r.evicted_id    = held_ids[SLOT_W'(oldest_pos)];
            held_ids[SLOT_W'((oldest_pos + held_total) % DEPTH)] = item.id_value;
            oldest_pos  = (oldest_pos + 1) % DEPTH;
            r.occupancy = OCC_W'(held_total);
         end else begin
            held_ids[SLOT_W'((oldest_pos + held_total) % DEPTH)] = item.id_value;
            held_total++;
            r.occupancy = OCC_W'(held_total);
         end
         queue_result(r);
      end
   endtask

   // ------------------------------------------------------------------
   // Mismatch reporting: one line per fault, printing capped, counting not
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                  input logic [ID_W-1:0] want);
      fail_count++;
      if (fail_count <= REPORT_LINES)
         $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want,
                  results_checked);
   endtask

   // ------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         // Check the response transaction first; its request was accepted earlier.
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_chan.payload.entry_id, '0);
            end else begin
               wanted = pending_results.pop_front();
               if (rsp_chan.payload.hit !== wanted.hit)
                  report_mismatch("hit", ID_W'(rsp_chan.payload.hit), ID_W'(wanted.hit));
               if (rsp_chan.payload.evicted_valid !== wanted.evicted_valid)
                  report_mismatch("evicted_valid", ID_W'(rsp_chan.payload.evicted_valid),
                                  ID_W'(wanted.evicted_valid));
               if (rsp_chan.payload.evicted_id !== wanted.evicted_id)
                  report_mismatch("evicted_id", rsp_chan.payload.evicted_id,
                                  wanted.evicted_id);
               if (rsp_chan.payload.occupancy !== wanted.occupancy)
                  report_mismatch("occupancy", ID_W'(rsp_chan.payload.occupancy),
                                  ID_W'(wanted.occupancy));
               if (rsp_chan.payload.entry_valid !== wanted.entry_valid)
                  report_mismatch("entry_valid", ID_W'(rsp_chan.payload.entry_valid),
                                  ID_W'(wanted.entry_valid));
               if (rsp_chan.payload.entry_id !== wanted.entry_id)
                  report_mismatch("entry_id", rsp_chan.payload.entry_id, wanted.entry_id);
               if (rsp_chan.payload.last !== wanted.last)
                  report_mismatch("last", ID_W'(rsp_chan.payload.last), ID_W'(wanted.last));
            end
         end
         // Predict on every accepted request; a typed row overrides its own result.
         if (req_chan.valid && req_chan.ready) begin
            predict_results(req_chan.payload);
            if (cur_row.has_typed)
               pending_results[pending_results.size() - 1] = cur_row.typed_rsp;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response side: random back-pressure, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            // Hold ready low and count the stretch here, so the block stalls on its result.
            hold_off_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= idle_percent);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run when nothing moves on either channel for too long
   // ------------------------------------------------------------------
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      wait (!reset);
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TIMEOUT: no transaction for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------

   // Offer one request transaction: idle at random first, then hold until accepted.
   task automatic send_item(input row_type row);
      @(negedge clock);
      while ($urandom_range(99) < idle_percent) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= row.item;
      cur_row          <= row;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted result has been seen.
   task automatic drain_results;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Write the capacity register; only ever done with the block idle.
   task automatic write_capacity(input logic [CSR_W-1:0] value);
      drain_results();
      csr_we           <= 1'b1;
      csr_wdata        <= value;
      capacity_setting  = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      row_type     row;
      int          phase;
      int          n;
      int          pool_span;

      // Initialise every input before the first edge.
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      cur_row          = '0;

      // Predictor reset state mirrors the block's.
      held_total       = 0;
      oldest_pos       = 0;
      capacity_setting = CAPACITY_RESET;

      // Directed table. Typed results only where they are plain to see.
      add_row(typed_row(dump_row(), 1'b0, 1'b0, '0, 5'd0, 1'b0, '0)); // empty dump
      add_row(typed_row(offer_row('0), 1'b0, 1'b0, '0, 5'd1, 1'b0, '0));
      add_row(typed_row(offer_row('1), 1'b0, 1'b0, '0, 5'd2, 1'b0, '0));
      add_row(typed_row(offer_row('0), 1'b1, 1'b0, '0, 5'd2, 1'b0, '0)); // hit
      add_row(dump_row());
      add_row(capacity_row(5'd1));
      add_row(typed_row(offer_row(32'd5), 1'b0, 1'b0, '0, 5'd1, 1'b0, '0));
      add_row(typed_row(offer_row(32'd6), 1'b0, 1'b1, 32'd5, 5'd1, 1'b0, '0));
      // An evicted id is absent again, so offering it evicts once more.
      add_row(typed_row(offer_row(32'd5), 1'b0, 1'b1, 32'd6, 5'd1, 1'b0, '0));
      add_row(typed_row(offer_row(32'd5), 1'b1, 1'b0, '0, 5'd1, 1'b0, '0));
      add_row(typed_row(dump_row(), 1'b0, 1'b0, '0, 5'd1, 1'b1, 32'd5));
      add_row(capacity_row(5'd0)); // zero behaves as one
      add_row(offer_row(32'hAAAA_5555));
      add_row(offer_row(32'h5555_AAAA));
      add_row(capacity_row(5'd16));
      add_row(offer_row(32'd1));
      add_row(offer_row(32'd2));
      add_row(offer_row(32'd3));
      add_row(offer_row(32'd4));
      // Lower capacity below occupancy: occupancy holds while the oldest goes.
      add_row(capacity_row(5'd2));
      add_row(offer_row(32'd6));
      add_row(offer_row(32'd3));
      add_row(capacity_row(5'd31)); // above DEPTH behaves as DEPTH
      add_row(offer_row(32'd7));
      add_row(dump_row());

      // Hold reset, then release it at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_CAPACITY)
            write_capacity(directed_rows[n].capacity);
         else
            send_item(directed_rows[n]);
      end

      // Random phases: a small pool of recurring ids gives hits and evictions,
      // fresh ids cover every bit, and the odd dump empties the store.
      foreach (id_pool[n]) id_pool[n] = $urandom();
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       write_capacity(5'd16);
            1:       write_capacity(5'd1);
            2:       write_capacity(5'd31);
            3:       write_capacity(5'd0);
            default: write_capacity(($urandom_range(3) == 0) ? CSR_W'($urandom_range(31))
                                                             : CSR_W'($urandom_range(1, 16)));
         endcase
         pool_span = $urandom_range(3, POOL_SIZE);
         // Stall the response side for a long stretch while requests keep coming.
         if (phase == 4) hold_off_request = 1'b1;
         // Run one phase flat out on both sides.
         idle_percent = (phase == 5) ? 0 : NORMAL_IDLE_PCT;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Pause the sender mid-phase until every result has arrived.
            if (phase == 2 && n == PHASE_ITEMS / 2) drain_results();
            if ($urandom_range(15) == 0)
               row = dump_row();
            else if ($urandom_range(4) == 0)
               row = offer_row($urandom());
            else
               row = offer_row(id_pool[POOL_IDX_W'($urandom_range(pool_span - 1))]);
            send_item(row);
         end
      end
      idle_percent = NORMAL_IDLE_PCT;

      // Let the tail drain, then allow the latency of a full dump for stray results.
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", ID_W'(pending_results.size()), '0);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
